[design/att_pkg.sv]
// att_pkg: shared types, sizes and codes of the allocation tracking table
`timescale 1ns / 1ps
`default_nettype none
package att_pkg;

  // table geometry
  localparam int BUCKETS      = 64;
  localparam int CHAIN_LIMIT  = 4;
  localparam int POOL_ENTRIES = 64;
  localparam int ADDR_W       = 32;
  localparam int BKT_W        = $clog2(BUCKETS);
  localparam int SLOT_W       = $clog2(POOL_ENTRIES);
  localparam int PTR_W        = $clog2(POOL_ENTRIES + 1);
  localparam int LEN_W        = $clog2(CHAIN_LIMIT + 1);
  localparam int NUM_STATS    = 14;

  // operation codes
  localparam logic [2:0] OP_MALLOC  = 3'd0;
  localparam logic [2:0] OP_CALLOC  = 3'd1;
  localparam logic [2:0] OP_REALLOC = 3'd2;
  localparam logic [2:0] OP_FREE    = 3'd3;
  localparam logic [2:0] OP_TICK    = 3'd4;
  localparam logic [2:0] OP_READ    = 3'd5;
  localparam logic [2:0] OP_CLEAR   = 3'd6;

  // status codes
  localparam logic [2:0] STS_TRACKED   = 3'd0;
  localparam logic [2:0] STS_UNTRACKED = 3'd1;
  localparam logic [2:0] STS_FAILED    = 3'd2;
  localparam logic [2:0] STS_INVALID   = 3'd3;
  localparam logic [2:0] STS_NULL      = 3'd4;
  localparam logic [2:0] STS_DONE      = 3'd5;

  // statistic counter indexes
  localparam int IX_CUR       = 0;
  localparam int IX_PEAK      = 1;
  localparam int IX_TALLOC    = 2;
  localparam int IX_TFREED    = 3;
  localparam int IX_MALLOC    = 4;
  localparam int IX_CALLOC    = 5;
  localparam int IX_REALLOC   = 6;
  localparam int IX_FREE      = 7;
  localparam int IX_FMALLOC   = 8;
  localparam int IX_FCALLOC   = 9;
  localparam int IX_FREALLOC  = 10;
  localparam int IX_INVALID   = 12;
  localparam int IX_UNTRACKED = 13;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] old_address;
    logic [31:0] new_address;
    logic [31:0] byte_size;
    logic [31:0] element_count;
    logic [3:0]  stat_index;
  } att_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] stat_value;
    logic [6:0]  live_entries;
  } att_rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [31:0]       size;
    logic [PTR_W-1:0]  link;
  } entry_t;

  typedef enum logic [1:0] {
    K_MALLOC,
    K_CALLOC,
    K_REALLOC,
    K_FREE
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_CALLOC,
    S_HEAD,
    S_HEADQ,
    S_ENTRY,
    S_REALLOC,
    S_UNLINK,
    S_COMPACT,
    S_INSERT,
    S_STATS,
    S_FINISH
  } state_t;

endpackage
`default_nettype wire

[design/att_ram.sv]
// att_ram: generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module att_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[design/allocation_tracking_table.sv]
// allocation_tracking_table: top level sequencer of the allocation tracking table
//
// Watches allocator events and keeps a hashed table of live blocks.
// Input channel in_valid / in_ready / in_data carries one request (malloc,
// calloc, realloc, free, tick, statistic read or clear); the result channel
// out_valid / out_ready / out_data returns exactly one response per request.
// Bucket heads and the entry pool live in two rams with registered read; the
// sequencer walks a bucket chain one entry per cycle, then writes back.
// Pool compaction after an unlink drops freed slots from the top of the pool.
// One request is worked on at a time; the next one is taken while a result
// still waits in the output register, and the sequencer holds its result if
// the receiver stalls. Reset (rst_n low, synchronous) empties the table, the
// pool and all counters at once through valid bits; no clearing pass is run.
`timescale 1ns / 1ps
`default_nettype none
module allocation_tracking_table (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire att_pkg::att_req_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output att_pkg::att_rsp_t      out_data
);
  import att_pkg::*;

  // sequencer state
  state_t            state_r, state_nxt;
  att_req_t          req_r, req_nxt;
  kind_t             kind_r, kind_nxt;
  logic [ADDR_W-1:0] key_r, key_nxt;
  logic [31:0]       size_r, size_nxt;
  logic              walk_add_r, walk_add_nxt;
  logic [PTR_W-1:0]  cur_r, cur_nxt;
  logic [PTR_W-1:0]  prev_r, prev_nxt;
  entry_t            prev_word_r, prev_word_nxt;
  logic              found_r, found_nxt;
  logic [PTR_W-1:0]  fptr_r, fptr_nxt;
  entry_t            fword_r, fword_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic              add_fail_r, add_fail_nxt;
  logic [63:0]       prod_r;
  logic [BUCKETS-1:0]      hv_r, hv_nxt;
  logic [POOL_ENTRIES-1:0] used_r, used_nxt;
  logic [PTR_W-1:0]  pool_top_r, pool_top_nxt;
  logic [PTR_W-1:0]  live_r, live_nxt;
  logic [31:0]       tick_r, tick_nxt;
  logic [31:0]       stats_r [NUM_STATS];
  logic [31:0]       stats_nxt [NUM_STATS];
  logic [2:0]        st_r, st_nxt;
  logic [31:0]       val_r, val_nxt;
  logic              out_valid_r, out_valid_nxt;
  att_rsp_t          out_data_r, out_data_nxt;

  // ram ports
  logic              hd_we;
  logic [PTR_W-1:0]  hd_wdata, hd_q;
  logic [BKT_W-1:0]  bkt;
  logic              ent_we;
  logic [SLOT_W-1:0] ent_waddr, ent_raddr;
  entry_t            ent_wdata, ent_q;
  logic [$bits(entry_t)-1:0] ent_q_raw;

  // walk helpers
  logic [PTR_W-1:0]  head_p;
  logic [LEN_W-1:0]  len_inc;
  logic [31:0]       old_sz;
  logic [31:0]       cur_new;
  logic              post_realloc;

  assign bkt     = key_r[4 +: BKT_W];
  assign ent_q   = entry_t'(ent_q_raw);
  assign head_p  = hv_r[bkt] ? hd_q : '0;
  assign len_inc = len_r + LEN_W'(1);
  assign old_sz  = found_r ? fword_r.size : 32'd0;

  att_ram #(.WIDTH(PTR_W), .DEPTH(BUCKETS)) u_head_ram (
    .clk   (clk),
    .we    (hd_we),
    .waddr (bkt),
    .wdata (hd_wdata),
    .raddr (bkt),
    .rdata (hd_q)
  );

  att_ram #(.WIDTH($bits(entry_t)), .DEPTH(POOL_ENTRIES)) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_q_raw)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // calloc product, one multiplier
  always_ff @(posedge clk) begin
    prod_r <= {32'd0, req_r.element_count} * {32'd0, req_r.byte_size};
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hv_r        <= '0;
      used_r      <= '0;
      pool_top_r  <= '0;
      live_r      <= '0;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_STATS; i++) begin
        stats_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      hv_r        <= hv_nxt;
      used_r      <= used_nxt;
      pool_top_r  <= pool_top_nxt;
      live_r      <= live_nxt;
      tick_r      <= tick_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < NUM_STATS; i++) begin
        stats_r[i] <= stats_nxt[i];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    kind_r      <= kind_nxt;
    key_r       <= key_nxt;
    size_r      <= size_nxt;
    walk_add_r  <= walk_add_nxt;
    cur_r       <= cur_nxt;
    prev_r      <= prev_nxt;
    prev_word_r <= prev_word_nxt;
    found_r     <= found_nxt;
    fptr_r      <= fptr_nxt;
    fword_r     <= fword_nxt;
    len_r       <= len_nxt;
    head_r      <= head_nxt;
    add_fail_r  <= add_fail_nxt;
    st_r        <= st_nxt;
    val_r       <= val_nxt;
    out_data_r  <= out_data_nxt;
  end

  // next state and datapath
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    kind_nxt      = kind_r;
    key_nxt       = key_r;
    size_nxt      = size_r;
    walk_add_nxt  = walk_add_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    prev_word_nxt = prev_word_r;
    found_nxt     = found_r;
    fptr_nxt      = fptr_r;
    fword_nxt     = fword_r;
    len_nxt       = len_r;
    head_nxt      = head_r;
    add_fail_nxt  = add_fail_r;
    hv_nxt        = hv_r;
    used_nxt      = used_r;
    pool_top_nxt  = pool_top_r;
    live_nxt      = live_r;
    tick_nxt      = tick_r;
    st_nxt        = st_r;
    val_nxt       = val_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    for (int i = 0; i < NUM_STATS; i++) begin
      stats_nxt[i] = stats_r[i];
    end
    hd_we        = 1'b0;
    hd_wdata     = '0;
    ent_we       = 1'b0;
    ent_waddr    = '0;
    ent_wdata    = '0;
    ent_raddr    = '0;
    cur_new      = '0;
    post_realloc = (kind_r == K_REALLOC);

    // result register drains independently
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        st_nxt       = STS_DONE;
        val_nxt      = '0;
        found_nxt    = 1'b0;
        add_fail_nxt = 1'b0;
        walk_add_nxt = 1'b0;
        size_nxt     = req_r.byte_size;
        state_nxt    = S_FINISH;
        case (req_r.operation) inside
          OP_MALLOC, OP_REALLOC: begin
            if (req_r.operation == OP_MALLOC || req_r.old_address == '0) begin
              // malloc, or realloc of null
              kind_nxt = K_MALLOC;
              if (req_r.new_address == '0) begin
                stats_nxt[IX_FMALLOC] = stats_r[IX_FMALLOC] + 32'd1;
                st_nxt = STS_FAILED;
              end else begin
                key_nxt      = req_r.new_address;
                walk_add_nxt = 1'b1;
                state_nxt    = S_HEAD;
              end
            end else begin
              kind_nxt  = (req_r.byte_size == '0) ? K_FREE : K_REALLOC;
              key_nxt   = req_r.old_address;
              state_nxt = S_HEAD;
            end
          end
          OP_CALLOC: begin
            kind_nxt  = K_CALLOC;
            state_nxt = S_CALLOC;
          end
          OP_FREE: begin
            kind_nxt = K_FREE;
            if (req_r.old_address == '0) begin
              st_nxt = STS_NULL;
            end else begin
              key_nxt   = req_r.old_address;
              state_nxt = S_HEAD;
            end
          end
          OP_TICK: begin
            tick_nxt = tick_r + 32'd1;
          end
          OP_READ: begin
            if (req_r.stat_index < 4'(NUM_STATS)) begin
              val_nxt = stats_r[req_r.stat_index];
            end
          end
          OP_CLEAR: begin
            hv_nxt       = '0;
            used_nxt     = '0;
            pool_top_nxt = '0;
            live_nxt     = '0;
            for (int i = 0; i < NUM_STATS; i++) begin
              stats_nxt[i] = '0;
            end
          end
          default: begin
          end
        endcase
      end

      // overflow or null check on the registered product
      S_CALLOC: begin
        if (prod_r[63:32] != '0 || req_r.new_address == '0) begin
          stats_nxt[IX_FCALLOC] = stats_r[IX_FCALLOC] + 32'd1;
          st_nxt    = STS_FAILED;
          state_nxt = S_FINISH;
        end else begin
          size_nxt     = prod_r[31:0];
          key_nxt      = req_r.new_address;
          walk_add_nxt = 1'b1;
          state_nxt    = S_HEAD;
        end
      end

      // head ram read in flight
      S_HEAD: begin
        state_nxt = S_HEADQ;
      end

      // start of chain walk
      S_HEADQ: begin
        head_nxt = head_p;
        cur_nxt  = head_p;
        prev_nxt = '0;
        len_nxt  = '0;
        if (head_p == '0) begin
          if (walk_add_r) begin
            state_nxt = S_INSERT;
          end else begin
            state_nxt = (kind_r == K_REALLOC) ? S_REALLOC : S_STATS;
          end
        end else begin
          ent_raddr = SLOT_W'(head_p - PTR_W'(1));
          state_nxt = S_ENTRY;
        end
      end

      // one chain entry per cycle
      S_ENTRY: begin
        if (walk_add_r) begin
          len_nxt = len_inc;
          if (len_inc >= LEN_W'(CHAIN_LIMIT)) begin
            add_fail_nxt = 1'b1;
            state_nxt    = S_STATS;
          end else if (ent_q.link == '0) begin
            state_nxt = S_INSERT;
          end else begin
            ent_raddr = SLOT_W'(ent_q.link - PTR_W'(1));
          end
        end else if (ent_q.address == key_r) begin
          found_nxt = 1'b1;
          fptr_nxt  = cur_r;
          fword_nxt = ent_q;
          state_nxt = (kind_r == K_REALLOC) ? S_REALLOC : S_UNLINK;
        end else if (ent_q.link == '0) begin
          state_nxt = (kind_r == K_REALLOC) ? S_REALLOC : S_STATS;
        end else begin
          prev_nxt      = cur_r;
          prev_word_nxt = ent_q;
          cur_nxt       = ent_q.link;
          ent_raddr     = SLOT_W'(ent_q.link - PTR_W'(1));
        end
        if (walk_add_r && ent_q.link != '0) begin
          cur_nxt = ent_q.link;
        end
      end

      // realloc decision after the lookup
      S_REALLOC: begin
        if (req_r.new_address == '0) begin
          state_nxt = S_STATS;
        end else if (found_r && req_r.new_address == req_r.old_address) begin
          ent_we         = 1'b1;
          ent_waddr      = SLOT_W'(fptr_r - PTR_W'(1));
          ent_wdata      = fword_r;
          ent_wdata.size = req_r.byte_size;
          state_nxt      = S_STATS;
        end else if (found_r) begin
          state_nxt = S_UNLINK;
        end else begin
          key_nxt      = req_r.new_address;
          walk_add_nxt = 1'b1;
          state_nxt    = S_HEAD;
        end
      end

      // unlink the found entry and release its slot
      S_UNLINK: begin
        if (prev_r == '0) begin
          hd_we    = 1'b1;
          hd_wdata = fword_r.link;
        end else begin
          ent_we         = 1'b1;
          ent_waddr      = SLOT_W'(prev_r - PTR_W'(1));
          ent_wdata      = prev_word_r;
          ent_wdata.link = fword_r.link;
        end
        used_nxt[SLOT_W'(fptr_r - PTR_W'(1))] = 1'b0;
        live_nxt = live_r - PTR_W'(1);
        if (fptr_r == pool_top_r) begin
          pool_top_nxt = pool_top_r - PTR_W'(1);
          state_nxt    = S_COMPACT;
        end else if (post_realloc) begin
          key_nxt      = req_r.new_address;
          walk_add_nxt = 1'b1;
          state_nxt    = S_HEAD;
        end else begin
          state_nxt = S_STATS;
        end
      end

      // drop freed slots from the top of the pool
      S_COMPACT: begin
        if (pool_top_r != '0 && !used_r[SLOT_W'(pool_top_r - PTR_W'(1))]) begin
          pool_top_nxt = pool_top_r - PTR_W'(1);
        end else if (post_realloc) begin
          key_nxt      = req_r.new_address;
          walk_add_nxt = 1'b1;
          state_nxt    = S_HEAD;
        end else begin
          state_nxt = S_STATS;
        end
      end

      // new entry at the top of the pool, in front of the chain
      S_INSERT: begin
        if (pool_top_r < PTR_W'(POOL_ENTRIES)) begin
          ent_we            = 1'b1;
          ent_waddr         = pool_top_r[SLOT_W-1:0];
          ent_wdata.address = key_r;
          ent_wdata.size    = size_r;
          ent_wdata.link    = head_r;
          hd_we             = 1'b1;
          hd_wdata          = pool_top_r + PTR_W'(1);
          hv_nxt[bkt]       = 1'b1;
          used_nxt[pool_top_r[SLOT_W-1:0]] = 1'b1;
          pool_top_nxt      = pool_top_r + PTR_W'(1);
          live_nxt          = live_r + PTR_W'(1);
        end else begin
          add_fail_nxt = 1'b1;
        end
        state_nxt = S_STATS;
      end

      // counter updates and status
      S_STATS: begin
        state_nxt = S_FINISH;
        case (kind_r) inside
          K_MALLOC, K_CALLOC: begin
            cur_new = stats_r[IX_CUR] + size_r;
            stats_nxt[IX_CUR]    = cur_new;
            stats_nxt[IX_TALLOC] = stats_r[IX_TALLOC] + size_r;
            if (kind_r == K_MALLOC) begin
              stats_nxt[IX_MALLOC] = stats_r[IX_MALLOC] + 32'd1;
            end else begin
              stats_nxt[IX_CALLOC] = stats_r[IX_CALLOC] + 32'd1;
            end
            if (cur_new > stats_r[IX_PEAK]) begin
              stats_nxt[IX_PEAK] = cur_new;
            end
            if (add_fail_r) begin
              stats_nxt[IX_UNTRACKED] = stats_r[IX_UNTRACKED] + 32'd1;
              st_nxt = STS_UNTRACKED;
            end else begin
              st_nxt = STS_TRACKED;
            end
          end
          K_REALLOC: begin
            if (req_r.new_address == '0) begin
              stats_nxt[IX_FREALLOC] = stats_r[IX_FREALLOC] + 32'd1;
              st_nxt = STS_FAILED;
            end else begin
              cur_new = stats_r[IX_CUR] - old_sz + size_r;
              stats_nxt[IX_CUR]     = cur_new;
              stats_nxt[IX_TALLOC]  = stats_r[IX_TALLOC] + size_r;
              stats_nxt[IX_TFREED]  = stats_r[IX_TFREED] + old_sz;
              stats_nxt[IX_REALLOC] = stats_r[IX_REALLOC] + 32'd1;
              if (cur_new > stats_r[IX_PEAK]) begin
                stats_nxt[IX_PEAK] = cur_new;
              end
              if (add_fail_r) begin
                stats_nxt[IX_UNTRACKED] = stats_r[IX_UNTRACKED] + 32'd1;
                st_nxt = STS_UNTRACKED;
              end else begin
                st_nxt = STS_TRACKED;
              end
            end
          end
          default: begin
            // a found size of zero reads as not found
            if (old_sz == '0) begin
              stats_nxt[IX_INVALID] = stats_r[IX_INVALID] + 32'd1;
              st_nxt = STS_INVALID;
            end else begin
              stats_nxt[IX_CUR]    = stats_r[IX_CUR] - old_sz;
              stats_nxt[IX_TFREED] = stats_r[IX_TFREED] + old_sz;
              stats_nxt[IX_FREE]   = stats_r[IX_FREE] + 32'd1;
              st_nxt = STS_DONE;
            end
          end
        endcase
      end

      // hand the result to the output register
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.status       = st_r;
          out_data_nxt.stat_value   = val_r;
          out_data_nxt.live_entries = 7'(live_r);
          out_valid_nxt             = 1'b1;
          state_nxt                 = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire
